### design/vn2d_pkg.sv
package vn2d_pkg;

  localparam int IN_W     = 16;
  localparam int FRAC_W   = 14;
  localparam int SQ_W     = 2 * IN_W;
  localparam int ACC_W    = 64;
  localparam int Q_W      = FRAC_W + 1;
  localparam int N_CELLS  = IN_W;
  localparam int IDX_W    = $clog2(N_CELLS);
  localparam int OUT_W    = 16;

  typedef struct packed {
    logic [Q_W-1:0]   q;
    logic [ACC_W-1:0] s1;
    logic [ACC_W-1:0] s2;
    logic [ACC_W-1:0] rhs;
  } unit_t;

  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] res;
    logic [SQ_W-1:0] d;
    logic            nx;
    logic            ny;
    unit_t           ux;
    unit_t           uy;
  } stage_t;

endpackage

### design/vn2d_cell.sv
module vn2d_cell (
  input  logic [vn2d_pkg::IDX_W-1:0] step_idx,
  input  vn2d_pkg::stage_t           cur,
  output vn2d_pkg::stage_t           nxt
);
  import vn2d_pkg::*;

  // one restoring divide-free step: accept bit b while (2c-1)^2 * d <= rhs
  function automatic unit_t unit_step(unit_t u, logic [SQ_W-1:0] dv, int b);
    unit_t            r;
    logic [ACC_W-1:0] d64;
    logic [ACC_W-1:0] t2d;
    r   = u;
    d64 = ACC_W'(dv);
    t2d = (u.s2 << 2) + (u.s1 << (b + 3)) - (u.s1 << 2)
        + (d64 << (2 * b + 2)) - (d64 << (b + 2)) + d64;
    if (t2d <= u.rhs) begin
      r.q  = u.q | Q_W'(1 << b);
      r.s2 = u.s2 + (u.s1 << (b + 1)) + (d64 << (2 * b));
      r.s1 = u.s1 + (d64 << b);
    end
    return r;
  endfunction

  logic [SQ_W-1:0] sq_bit;
  logic [SQ_W-1:0] trial;
  int              ub;

  always_comb begin
    nxt    = cur;
    sq_bit = SQ_W'(1) << (SQ_W - 2 - 2 * int'(step_idx));
    trial  = cur.res + sq_bit;
    if (cur.rem >= trial) begin
      nxt.rem = cur.rem - trial;
      nxt.res = (cur.res >> 1) + sq_bit;
    end else begin
      nxt.res = cur.res >> 1;
    end
    ub = FRAC_W - int'(step_idx);
    if (ub >= 0) begin
      nxt.ux = unit_step(cur.ux, cur.d, ub);
      nxt.uy = unit_step(cur.uy, cur.d, ub);
    end
  end

endmodule

### design/vector_normalize_2d_top.sv
// channel | ports                                   | direction
// input   | in_valid, in_stall, in_x_in, in_y_in    | item in, Q8.8 pair
// output  | out_valid, out_stall, out_length_out,   | item out, unsigned Q8.8 length,
//         | out_unit_x, out_unit_y, out_degenerate  | Q1.14 unit vector
//
// One item per cycle while out_stall is low; the stages are the input square stage,
// 16 cells of the sqrt / reciprocal chain and the output register.
// Each cell does one square-root bit; all but the last also do one quotient bit per component.
// rst_n (synchronous, active low) clears the valid bits only.
// A stage loads whenever it is empty or its successor loads, so bubbles
// collapse under out_stall; in_stall rises only when every stage is full.
module vector_normalize_2d_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [15:0]  in_x_in,
  input  logic signed [15:0]  in_y_in,
  output logic                out_valid,
  input  logic                out_stall,
  output logic        [15:0]  out_length_out,
  output logic signed [15:0]  out_unit_x,
  output logic signed [15:0]  out_unit_y,
  output logic                out_degenerate
);
  import vn2d_pkg::*;

  localparam int NS = N_CELLS + 1;

  stage_t         st_r   [NS];
  stage_t         cell_o [N_CELLS];
  logic [NS-1:0]  v_r;
  logic [NS:0]    load;

  logic [IN_W-1:0] ax, ay;
  logic [SQ_W-1:0] ax2, ay2;
  stage_t          in_st;

  logic             out_valid_r;
  logic [OUT_W-1:0] len_r;
  logic [OUT_W-1:0] ux_r, uy_r;
  logic             deg_r;

  // load chain: stage k takes an item when empty or when stage k+1 takes
  always_comb begin
    load[NS] = !out_valid_r || !out_stall;
    for (int k = NS - 1; k >= 0; k--) begin
      load[k] = !v_r[k] || load[k+1];
    end
  end

  assign in_stall = !load[0];

  // magnitudes and squares of the incoming item
  always_comb begin
    ax  = in_x_in[IN_W-1] ? IN_W'(-in_x_in) : IN_W'(in_x_in);
    ay  = in_y_in[IN_W-1] ? IN_W'(-in_y_in) : IN_W'(in_y_in);
    ax2 = SQ_W'(ax) * SQ_W'(ax);
    ay2 = SQ_W'(ay) * SQ_W'(ay);
    in_st        = '0;
    in_st.d      = ax2 + ay2;
    in_st.rem    = ax2 + ay2;
    in_st.nx     = in_x_in[IN_W-1];
    in_st.ny     = in_y_in[IN_W-1];
    in_st.ux.rhs = ACC_W'(ax2) << (2 * FRAC_W + 2);
    in_st.uy.rhs = ACC_W'(ay2) << (2 * FRAC_W + 2);
  end

  for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
    vn2d_cell u_cell (
      .step_idx (IDX_W'(g)),
      .cur      (st_r[g]),
      .nxt      (cell_o[g])
    );
  end

  // advance the chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (load[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (load[k]) v_r[k] <= v_r[k-1];
      end
    end
    if (load[0]) st_r[0] <= in_st;
    for (int k = 1; k < NS; k++) begin
      if (load[k]) st_r[k] <= cell_o[k-1];
    end
  end

  // format the result; a zero vector forces length 0 and unit (1.0, 0)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load[NS]) begin
      out_valid_r <= v_r[NS-1];
    end
    if (load[NS]) begin
      if (st_r[NS-1].d == '0) begin
        len_r <= '0;
        ux_r  <= OUT_W'(1 << FRAC_W);
        uy_r  <= '0;
        deg_r <= 1'b1;
      end else begin
        len_r <= st_r[NS-1].res[OUT_W-1:0];
        ux_r  <= st_r[NS-1].nx ? -OUT_W'(st_r[NS-1].ux.q) : OUT_W'(st_r[NS-1].ux.q);
        uy_r  <= st_r[NS-1].ny ? -OUT_W'(st_r[NS-1].uy.q) : OUT_W'(st_r[NS-1].uy.q);
        deg_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_length_out = len_r;
  assign out_unit_x     = ux_r;
  assign out_unit_y     = uy_r;
  assign out_degenerate = deg_r;

`ifndef SYNTH
  a_deg_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_length_out == 16'd0 && out_unit_x == 16'sd16384 && out_unit_y == 16'sd0)
    else $error("degenerate item not forced to unit (1,0)");
  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_unit_x <= 16'sd16384 && out_unit_x >= -16'sd16384 &&
                  out_unit_y <= 16'sd16384 && out_unit_y >= -16'sd16384)
    else $error("unit component beyond full scale");
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall && (&v_r))
    else $error("input stalled while the chain has room");
`endif

endmodule
